// ----- src/hsoc_pkg.sv -----
// Shared constants, types and codes of the hard-sphere overlap checker.
package hsoc_pkg;

  // Store size and fixed-point format
  localparam int MAX_PARTICLES = 1024;
  localparam int FRAC_BITS     = 16;
  localparam int ADDR_W        = $clog2(MAX_PARTICLES);
  localparam int NUM_W         = ADDR_W + 1;

  // Field widths
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int POS_W   = 32;
  localparam int DIAM_W  = 31;
  localparam int BOX_W   = 31;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // Arithmetic widths
  localparam int DIFF_W = POS_W + 1;
  localparam int FOLD_W = POS_W + 2;
  localparam int MAG_W  = 32;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ACC_W  = SQ_W + 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);
  localparam logic [BOX_W-1:0] BOX_RESET   = BOX_W'(1 << FRAC_BITS);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  typedef enum logic [1:0] {
    REG_COUNT = 2'd0,
    REG_BOX_X = 2'd1,
    REG_BOX_Y = 2'd2,
    REG_BOX_Z = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV_WB,
    ST_PRIME,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Operand slot of the shared squaring unit
  typedef enum logic [1:0] {
    PH_X    = 2'd0,
    PH_Y    = 2'd1,
    PH_Z    = 2'd2,
    PH_DIAM = 2'd3
  } ph_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [DIAM_W-1:0]       diam;
  } entry_t;

  typedef struct packed {
    logic valid;
    ph_t  ph;
    logic self;
    logic last;
  } tag_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              wr_move;
    logic [ADDR_W-1:0] wr_addr;
    logic              cap_disp;
    logic              cap_mov;
    logic              feed;
    ph_t               ph;
    logic              self;
    logic              last;
    logic              clr_hit;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } sts_t;

endpackage

// ----- src/hsoc_if.sv -----
// Valid/ready channel interfaces for items and results.
interface hsoc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [hsoc_pkg::IDX_W-1:0]          particle_index;
  logic signed [hsoc_pkg::POS_W-1:0]   value_x;
  logic signed [hsoc_pkg::POS_W-1:0]   value_y;
  logic signed [hsoc_pkg::POS_W-1:0]   value_z;
  logic [hsoc_pkg::DIAM_W-1:0]         diameter;

  modport source (output valid, mode, particle_index, value_x, value_y, value_z, diameter,
                  input ready);
  modport sink (input valid, mode, particle_index, value_x, value_y, value_z, diameter,
                output ready);
endinterface

interface hsoc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       overlap;
  logic [hsoc_pkg::IDX_W-1:0] moved_index;

  modport source (output valid, overlap, moved_index, input ready);
  modport sink (input valid, overlap, moved_index, output ready);
endinterface

// ----- src/hsoc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module hsoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/hsoc_dp.sv -----
// Particle store, move write-back and the shared fold/square/accumulate unit.
module hsoc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hsoc_pkg::ctl_t                    ctl,
  input  logic signed [hsoc_pkg::POS_W-1:0] in_value_x,
  input  logic signed [hsoc_pkg::POS_W-1:0] in_value_y,
  input  logic signed [hsoc_pkg::POS_W-1:0] in_value_z,
  input  logic [hsoc_pkg::DIAM_W-1:0]       in_diameter,
  input  logic [hsoc_pkg::BOX_W-1:0]        box_x,
  input  logic [hsoc_pkg::BOX_W-1:0]        box_y,
  input  logic [hsoc_pkg::BOX_W-1:0]        box_z,
  output hsoc_pkg::sts_t                    sts
);

  hsoc_pkg::entry_t rd_q;
  hsoc_pkg::entry_t wr_d;
  logic [$bits(hsoc_pkg::entry_t)-1:0] rd_raw;

  // Moved particle: displacement, then updated position and diameter
  logic signed [hsoc_pkg::POS_W-1:0] disp_x_r, disp_y_r, disp_z_r;
  logic signed [hsoc_pkg::POS_W-1:0] mov_x_r, mov_y_r, mov_z_r;
  logic [hsoc_pkg::DIAM_W-1:0]       mov_d_r;
  logic signed [hsoc_pkg::POS_W-1:0] new_x, new_y, new_z;

  // Stage 1: difference or diameter sum
  hsoc_pkg::tag_t                     t1_r;
  logic signed [hsoc_pkg::DIFF_W-1:0] op_r, op_nxt;
  logic [hsoc_pkg::BOX_W-1:0]         len_r, len_nxt;
  // Stage 2: folded magnitude
  hsoc_pkg::tag_t                     t2_r;
  logic [hsoc_pkg::MAG_W-1:0]         mag_r, mag_nxt;
  logic signed [hsoc_pkg::FOLD_W-1:0] d_ext, two_d, l_pos, f_dn, f_up, f_sel, f_abs;
  // Stage 3: square
  hsoc_pkg::tag_t                     t3_r;
  logic [hsoc_pkg::SQ_W-1:0]          sq_r;
  // Stage 4: accumulate and compare
  logic [hsoc_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic                               hit_r, hit_nxt;
  logic                               close;

  hsoc_ram #(
    .WIDTH ($bits(hsoc_pkg::entry_t)),
    .DEPTH (hsoc_pkg::MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ctl.wr_addr),
    .wdata (wr_d),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (rd_raw)
  );

  assign rd_q = hsoc_pkg::entry_t'(rd_raw);

  // Position wraps in 32 bits
  assign new_x = rd_q.pos_x + disp_x_r;
  assign new_y = rd_q.pos_y + disp_y_r;
  assign new_z = rd_q.pos_z + disp_z_r;

  always_comb begin
    if (ctl.wr_move) begin
      wr_d.pos_x = new_x;
      wr_d.pos_y = new_y;
      wr_d.pos_z = new_z;
      wr_d.diam  = rd_q.diam;
    end else begin
      wr_d.pos_x = in_value_x;
      wr_d.pos_y = in_value_y;
      wr_d.pos_z = in_value_z;
      wr_d.diam  = in_diameter;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_disp) begin
      disp_x_r <= in_value_x;
      disp_y_r <= in_value_y;
      disp_z_r <= in_value_z;
    end
    if (ctl.cap_mov) begin
      mov_x_r <= new_x;
      mov_y_r <= new_y;
      mov_z_r <= new_z;
      mov_d_r <= rd_q.diam;
    end
  end

  // Stage 1 operand select; other particle comes straight off the RAM register
  always_comb begin
    case (ctl.ph)
      hsoc_pkg::PH_X: begin
        op_nxt  = $signed({mov_x_r[hsoc_pkg::POS_W-1], mov_x_r})
                - $signed({rd_q.pos_x[hsoc_pkg::POS_W-1], rd_q.pos_x});
        len_nxt = box_x;
      end
      hsoc_pkg::PH_Y: begin
        op_nxt  = $signed({mov_y_r[hsoc_pkg::POS_W-1], mov_y_r})
                - $signed({rd_q.pos_y[hsoc_pkg::POS_W-1], rd_q.pos_y});
        len_nxt = box_y;
      end
      hsoc_pkg::PH_Z: begin
        op_nxt  = $signed({mov_z_r[hsoc_pkg::POS_W-1], mov_z_r})
                - $signed({rd_q.pos_z[hsoc_pkg::POS_W-1], rd_q.pos_z});
        len_nxt = box_z;
      end
      default: begin
        op_nxt  = $signed({2'b00, mov_d_r} + {2'b00, rd_q.diam});
        len_nxt = '0;
      end
    endcase
  end

  // Stage 2: fold once by the box length, then magnitude (< 2^32 always)
  always_comb begin
    d_ext = {op_r[hsoc_pkg::DIFF_W-1], op_r};
    two_d = {op_r, 1'b0};
    l_pos = {3'b000, len_r};
    f_dn  = d_ext - l_pos;
    f_up  = d_ext + l_pos;
    if (two_d > l_pos) begin
      f_sel = f_dn;
    end else if (two_d < -l_pos) begin
      f_sel = f_up;
    end else begin
      f_sel = d_ext;
    end
    f_abs = f_sel[hsoc_pkg::FOLD_W-1] ? -f_sel : f_sel;
    if (t1_r.ph == hsoc_pkg::PH_DIAM) begin
      mag_nxt = op_r[hsoc_pkg::MAG_W-1:0];
    end else begin
      mag_nxt = f_abs[hsoc_pkg::MAG_W-1:0];
    end
  end

  // Stage 4: sum of squares, then 4*sum < (d1+d2)^2
  assign close = {acc_r, 2'b00} < {4'b0000, sq_r};

  always_comb begin
    acc_nxt = acc_r;
    hit_nxt = hit_r;
    if (ctl.clr_hit) begin
      hit_nxt = 1'b0;
    end else if (t3_r.valid) begin
      case (t3_r.ph)
        hsoc_pkg::PH_X:    acc_nxt = {2'b00, sq_r};
        hsoc_pkg::PH_Y,
        hsoc_pkg::PH_Z:    acc_nxt = acc_r + {2'b00, sq_r};
        default: begin
          if (close && !t3_r.self) begin
            hit_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t2_r  <= '0;
      t3_r  <= '0;
      hit_r <= 1'b0;
    end else begin
      t1_r.valid <= ctl.feed;
      t1_r.ph    <= ctl.ph;
      t1_r.self  <= ctl.self;
      t1_r.last  <= ctl.last;
      t2_r       <= t1_r;
      t3_r       <= t2_r;
      hit_r      <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    len_r <= len_nxt;
    mag_r <= mag_nxt;
    sq_r  <= mag_r * mag_r;
    acc_r <= acc_nxt;
  end

  assign sts.done = t3_r.valid && (t3_r.ph == hsoc_pkg::PH_DIAM) && t3_r.last;
  assign sts.hit  = hit_r;

endmodule

// ----- src/hsoc_ctrl.sv -----
// Sequencer: item handshake, store access order, operand feed and result register.
module hsoc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_mode,
  input  logic [hsoc_pkg::IDX_W-1:0]  in_index,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_overlap,
  output logic [hsoc_pkg::IDX_W-1:0]  out_index,
  input  logic [hsoc_pkg::NUM_W-1:0]  num,
  input  hsoc_pkg::sts_t              sts,
  output hsoc_pkg::ctl_t              ctl
);

  hsoc_pkg::state_t state_r, state_nxt;
  logic [hsoc_pkg::NUM_W-1:0] i_r, i_nxt, i_inc;
  hsoc_pkg::ph_t              ph_r, ph_nxt;
  logic [hsoc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_overlap_r, out_overlap_nxt;
  logic [hsoc_pkg::IDX_W-1:0] out_index_r, out_index_nxt;
  logic                       accept, idx_ok, more, emit;

  assign accept = in_valid && (state_r == hsoc_pkg::ST_IDLE);
  assign idx_ok = int'(in_index) < hsoc_pkg::MAX_PARTICLES;
  assign i_inc  = i_r + 1'b1;
  assign more   = i_inc < num;
  assign emit   = (state_r == hsoc_pkg::ST_FINISH) && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsoc_pkg::ST_IDLE: begin
        if (accept && in_mode == hsoc_pkg::MODE_MOVE) begin
          state_nxt = idx_ok ? hsoc_pkg::ST_MV_WB : hsoc_pkg::ST_FINISH;
        end
      end
      hsoc_pkg::ST_MV_WB: begin
        state_nxt = (num == '0) ? hsoc_pkg::ST_FINISH : hsoc_pkg::ST_PRIME;
      end
      hsoc_pkg::ST_PRIME: state_nxt = hsoc_pkg::ST_SCAN;
      hsoc_pkg::ST_SCAN: begin
        if (ph_r == hsoc_pkg::PH_DIAM && !more) begin
          state_nxt = hsoc_pkg::ST_DRAIN;
        end
      end
      hsoc_pkg::ST_DRAIN: begin
        if (sts.done) begin
          state_nxt = hsoc_pkg::ST_FINISH;
        end
      end
      hsoc_pkg::ST_FINISH: begin
        if (emit) begin
          state_nxt = hsoc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hsoc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    ctl.ph   = ph_r;
    in_ready = 1'b0;
    case (state_r)
      hsoc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && in_mode == hsoc_pkg::MODE_LOAD && idx_ok) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_addr = in_index[hsoc_pkg::ADDR_W-1:0];
        end
        if (accept && in_mode == hsoc_pkg::MODE_MOVE) begin
          ctl.clr_hit = 1'b1;
          if (idx_ok) begin
            ctl.rd_en    = 1'b1;
            ctl.rd_addr  = in_index[hsoc_pkg::ADDR_W-1:0];
            ctl.cap_disp = 1'b1;
          end
        end
      end
      hsoc_pkg::ST_MV_WB: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_move = 1'b1;
        ctl.wr_addr = idx_r[hsoc_pkg::ADDR_W-1:0];
        ctl.cap_mov = 1'b1;
      end
      hsoc_pkg::ST_PRIME: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = i_r[hsoc_pkg::ADDR_W-1:0];
      end
      hsoc_pkg::ST_SCAN: begin
        ctl.feed = 1'b1;
        ctl.self = (i_r == hsoc_pkg::NUM_W'(idx_r));
        ctl.last = !more;
        if (ph_r == hsoc_pkg::PH_DIAM && more) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = i_inc[hsoc_pkg::ADDR_W-1:0];
        end
      end
      hsoc_pkg::ST_DRAIN,
      hsoc_pkg::ST_FINISH: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Counters and result register
  always_comb begin
    i_nxt           = i_r;
    ph_nxt          = ph_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_overlap_nxt = out_overlap_r;
    out_index_nxt   = out_index_r;
    if (accept && in_mode == hsoc_pkg::MODE_MOVE) begin
      idx_nxt = in_index;
    end
    if (state_r == hsoc_pkg::ST_MV_WB) begin
      i_nxt  = '0;
      ph_nxt = hsoc_pkg::PH_X;
    end
    if (state_r == hsoc_pkg::ST_SCAN) begin
      case (ph_r)
        hsoc_pkg::PH_X: ph_nxt = hsoc_pkg::PH_Y;
        hsoc_pkg::PH_Y: ph_nxt = hsoc_pkg::PH_Z;
        hsoc_pkg::PH_Z: ph_nxt = hsoc_pkg::PH_DIAM;
        default: begin
          ph_nxt = hsoc_pkg::PH_X;
          i_nxt  = i_inc;
        end
      endcase
    end
    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_overlap_nxt = sts.hit;
      out_index_nxt   = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsoc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      ph_r        <= hsoc_pkg::PH_X;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    out_overlap_r <= out_overlap_nxt;
    out_index_r   <= out_index_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;
  assign out_index   = out_index_r;

endmodule

// ----- src/hard_sphere_overlap_check.sv -----
// Top level of the hard-sphere overlap checker: registers, sequencer and datapath.
//
// Holds up to 1024 particles (position x/y/z, Q15.16 signed, and diameter) in
// one RAM. A load item (mode 0) writes one entry and gives no result. A move
// item (mode 1) adds its displacement to the stored position, writes the new
// position back unconditionally, then walks particles 0 to N-1,
// N = min(particle_count, 1024), skipping the moved particle itself. For each
// axis the difference is folded once by the box length (minimum image), the
// squares are summed and overlap is flagged when 4*sum < (d_moved + d_other)^2.
// One result item carries overlap and the moved index. One shared 32x32
// squaring multiplier takes four products per particle (x, y, z and the
// diameter sum), so the next item is not taken until a move is through and
// its result has been placed in the output register.
// in_ch.ready is high only while idle; a finished result waits in the output
// register, and a later move holds in its last cycle until that slot frees.
// Configuration (APB, writes only while idle): 0x0 particle_count,
// 0x4/0x8/0xC box length x/y/z. Store contents are undefined until loaded.
module hard_sphere_overlap_check (
  input  logic                          clk,
  input  logic                          rst_n,
  hsoc_in_if.sink                       in_ch,
  hsoc_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsoc_pkg::PADDR_W-1:0]  paddr,
  input  logic [hsoc_pkg::DATA_W-1:0]   pwdata,
  output logic [hsoc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [hsoc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [hsoc_pkg::BOX_W-1:0] box_x_r, box_x_nxt;
  logic [hsoc_pkg::BOX_W-1:0] box_y_r, box_y_nxt;
  logic [hsoc_pkg::BOX_W-1:0] box_z_r, box_z_nxt;
  logic [hsoc_pkg::NUM_W-1:0] num;
  logic                       cfg_wr;
  hsoc_pkg::reg_t             reg_sel;
  hsoc_pkg::ctl_t             ctl;
  hsoc_pkg::sts_t             sts;

  // Config port: pready always high, word aligned registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = hsoc_pkg::reg_t'(paddr[3:2]);

  always_comb begin
    count_nxt = count_r;
    box_x_nxt = box_x_r;
    box_y_nxt = box_y_r;
    box_z_nxt = box_z_r;
    if (cfg_wr) begin
      case (reg_sel)
        hsoc_pkg::REG_COUNT: count_nxt = pwdata[hsoc_pkg::CNT_W-1:0];
        hsoc_pkg::REG_BOX_X: box_x_nxt = pwdata[hsoc_pkg::BOX_W-1:0];
        hsoc_pkg::REG_BOX_Y: box_y_nxt = pwdata[hsoc_pkg::BOX_W-1:0];
        hsoc_pkg::REG_BOX_Z: box_z_nxt = pwdata[hsoc_pkg::BOX_W-1:0];
        default: count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= hsoc_pkg::COUNT_RESET;
      box_x_r <= hsoc_pkg::BOX_RESET;
      box_y_r <= hsoc_pkg::BOX_RESET;
      box_z_r <= hsoc_pkg::BOX_RESET;
    end else begin
      count_r <= count_nxt;
      box_x_r <= box_x_nxt;
      box_y_r <= box_y_nxt;
      box_z_r <= box_z_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      hsoc_pkg::REG_COUNT: prdata = hsoc_pkg::DATA_W'(count_r);
      hsoc_pkg::REG_BOX_X: prdata = hsoc_pkg::DATA_W'(box_x_r);
      hsoc_pkg::REG_BOX_Y: prdata = hsoc_pkg::DATA_W'(box_y_r);
      hsoc_pkg::REG_BOX_Z: prdata = hsoc_pkg::DATA_W'(box_z_r);
      default:             prdata = '0;
    endcase
  end

  // Counts above the store size saturate
  assign num = (int'(count_r) > hsoc_pkg::MAX_PARTICLES) ?
               hsoc_pkg::NUM_W'(hsoc_pkg::MAX_PARTICLES) : hsoc_pkg::NUM_W'(count_r);

  hsoc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_mode     (in_ch.mode),
    .in_index    (in_ch.particle_index),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_overlap (out_ch.overlap),
    .out_index   (out_ch.moved_index),
    .num         (num),
    .sts         (sts),
    .ctl         (ctl)
  );

  hsoc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_value_x  (in_ch.value_x),
    .in_value_y  (in_ch.value_y),
    .in_value_z  (in_ch.value_z),
    .in_diameter (in_ch.diameter),
    .box_x       (box_x_r),
    .box_y       (box_y_r),
    .box_z       (box_z_r),
    .sts         (sts)
  );

endmodule

// ----- src/hsoc_chk.sv -----
// Port-level checker for the overlap checker, bound to the top level.
module hsoc_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_mode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_overlap,
  input logic [hsoc_pkg::IDX_W-1:0] out_moved_index
);

  // A move occupies the block: not ready in the following cycle
  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == hsoc_pkg::MODE_MOVE) |=> !in_ready)
    else $error("ready after move item");

  // A load completes in its own cycle
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == hsoc_pkg::MODE_LOAD) |=> in_ready)
    else $error("not ready after load item");

  // A new result only comes out of a busy cycle, never straight from idle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a move");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_overlap) && $stable(out_moved_index)))
    else $error("stalled result changed");

endmodule

bind hard_sphere_overlap_check hsoc_chk u_hsoc_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_mode         (in_ch.mode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_overlap     (out_ch.overlap),
  .out_moved_index (out_ch.moved_index)
);

// ----- tb/hsoc_contact_checker.sv -----
// Scoreboard for the hard-sphere overlap checker: register shadow, particle store, result check.
module hsoc_contact_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  hsoc_in_if                           in_ch,
  hsoc_out_if                          out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsoc_pkg::PADDR_W-1:0] paddr,
  input  logic [hsoc_pkg::DATA_W-1:0]  pwdata,
  input  logic [hsoc_pkg::DATA_W-1:0]  prdata,
  input  logic                         pready,
  output int                           errors,
  output int                           waiting
);

  localparam int WIDE_W = hsoc_pkg::ACC_W + 4;

  typedef struct packed {
    logic                       overlap;
    logic [hsoc_pkg::IDX_W-1:0] moved_index;
  } verdict_t;

  logic signed [hsoc_pkg::POS_W-1:0] pos_x [hsoc_pkg::MAX_PARTICLES];
  logic signed [hsoc_pkg::POS_W-1:0] pos_y [hsoc_pkg::MAX_PARTICLES];
  logic signed [hsoc_pkg::POS_W-1:0] pos_z [hsoc_pkg::MAX_PARTICLES];
  logic [hsoc_pkg::DIAM_W-1:0]       diam  [hsoc_pkg::MAX_PARTICLES];

  logic [hsoc_pkg::CNT_W-1:0] n_particles;
  logic [hsoc_pkg::BOX_W-1:0] box_x, box_y, box_z;

  verdict_t verdicts_due[$];

  initial begin
    errors  = 0;
    waiting = 0;
  end

  // Squared minimum-image distance along one axis; one fold only.
  function automatic logic [WIDE_W-1:0] axis_sq(input logic signed [hsoc_pkg::POS_W-1:0] a,
                                                 input logic signed [hsoc_pkg::POS_W-1:0] b,
                                                 input logic [hsoc_pkg::BOX_W-1:0] len);
    longint            d;
    longint            l;
    logic [WIDE_W-1:0] mag;
    d = longint'(a) - longint'(b);
    l = longint'(len);
    if (2 * d > l) begin
      d = d - l;
    end else if (2 * d < -l) begin
      d = d + l;
    end
    mag = WIDE_W'((d < 0) ? -d : d);
    return mag * mag;
  endfunction

  // 4*|r|^2 < (d_a + d_b)^2
  function automatic logic touches(input int unsigned mv, input int unsigned other);
    logic [WIDE_W-1:0] dist4;
    logic [WIDE_W-1:0] dsum;
    dist4 = axis_sq(pos_x[mv], pos_x[other], box_x)
          + axis_sq(pos_y[mv], pos_y[other], box_y)
          + axis_sq(pos_z[mv], pos_z[other], box_z);
    dist4 = dist4 << 2;
    dsum  = WIDE_W'(diam[mv]) + WIDE_W'(diam[other]);
    return dist4 < dsum * dsum;
  endfunction

  always @(posedge clk) begin
    verdict_t                    got;
    verdict_t                    want;
    logic [hsoc_pkg::DATA_W-1:0] shadow;
    int unsigned                 idx;
    int unsigned                 limit;
    logic                        hit;
    if (!rst_n) begin
      n_particles = hsoc_pkg::COUNT_RESET;
      box_x       = hsoc_pkg::BOX_RESET;
      box_y       = hsoc_pkg::BOX_RESET;
      box_z       = hsoc_pkg::BOX_RESET;
      verdicts_due.delete();
      waiting     = 0;
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (hsoc_pkg::reg_t'(paddr[hsoc_pkg::PADDR_W-1:2]))
            hsoc_pkg::REG_COUNT: n_particles = pwdata[hsoc_pkg::CNT_W-1:0];
            hsoc_pkg::REG_BOX_X: box_x = pwdata[hsoc_pkg::BOX_W-1:0];
            hsoc_pkg::REG_BOX_Y: box_y = pwdata[hsoc_pkg::BOX_W-1:0];
            hsoc_pkg::REG_BOX_Z: box_z = pwdata[hsoc_pkg::BOX_W-1:0];
            default: ;
          endcase
        end else begin
          case (hsoc_pkg::reg_t'(paddr[hsoc_pkg::PADDR_W-1:2]))
            hsoc_pkg::REG_COUNT: shadow = hsoc_pkg::DATA_W'(n_particles);
            hsoc_pkg::REG_BOX_X: shadow = hsoc_pkg::DATA_W'(box_x);
            hsoc_pkg::REG_BOX_Y: shadow = hsoc_pkg::DATA_W'(box_y);
            default:             shadow = hsoc_pkg::DATA_W'(box_z);
          endcase
          if (prdata !== shadow) begin
            errors++;
            $display("%0t: register read at 0x%0h: expected 0x%08h, got 0x%08h",
                     $time, paddr, shadow, prdata);
          end
        end
      end

      // results first, so an item taken on the same edge never pairs with itself
      if (out_ch.valid && out_ch.ready) begin
        got = '{overlap: out_ch.overlap, moved_index: out_ch.moved_index};
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: got overlap=%0b index=%0d",
                   $time, got.overlap, got.moved_index);
        end else begin
          want = verdicts_due.pop_front();
          waiting--;
          if (got.overlap !== want.overlap || got.moved_index !== want.moved_index) begin
            errors++;
            $display({"%0t: result mismatch: expected overlap=%0b index=%0d, ",
                      "got overlap=%0b index=%0d"},
                     $time, want.overlap, want.moved_index, got.overlap, got.moved_index);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        idx = in_ch.particle_index;
        if (in_ch.mode == hsoc_pkg::MODE_LOAD) begin
          pos_x[idx] = in_ch.value_x;
          pos_y[idx] = in_ch.value_y;
          pos_z[idx] = in_ch.value_z;
          diam[idx]  = in_ch.diameter;
        end else begin
          pos_x[idx] = pos_x[idx] + in_ch.value_x;
          pos_y[idx] = pos_y[idx] + in_ch.value_y;
          pos_z[idx] = pos_z[idx] + in_ch.value_z;
          limit = (n_particles > hsoc_pkg::MAX_PARTICLES) ?
                  hsoc_pkg::MAX_PARTICLES : n_particles;
          hit   = 1'b0;
          for (int unsigned i = 0; i < limit && !hit; i++) begin
            if (i != idx && touches(idx, i)) hit = 1'b1;
          end
          verdicts_due.push_back('{overlap: hit, moved_index: in_ch.particle_index});
          waiting++;
        end
      end
    end
  end

endmodule

// ----- tb/tb_hard_sphere_overlap_check.sv -----
// Testbench top for the hard-sphere overlap checker: clock, reset, stimulus and verdict.
module tb_hard_sphere_overlap_check;

  localparam int UNIT        = 1 << hsoc_pkg::FRAC_BITS;  // 1.0 in Q15.16
  localparam int ITEM_BUDGET = 580;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [hsoc_pkg::PADDR_W-1:0] paddr;
  logic [hsoc_pkg::DATA_W-1:0]  pwdata;
  logic [hsoc_pkg::DATA_W-1:0]  prdata;
  logic                         pready;

  int errors;
  int waiting;
  int cycles      = 0;
  int sender_idle = 0;   // percent of cycles the source holds back
  int sink_stall  = 0;   // percent of cycles the sink refuses a result
  int cur_count   = 1;   // particle_count as last written
  int span_x, span_y, span_z;  // extent used to place particles per axis
  int items_sent  = 0;
  int phase;

  hsoc_in_if  in_ch();
  hsoc_out_if out_ch();

  hard_sphere_overlap_check dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hsoc_contact_checker contact_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .errors  (errors),
    .waiting (waiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hang or a lost result ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: back-pressure drawn fresh every cycle, driven on the falling edge.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= sink_stall);
  end

  // Idle profiles: none, source idle, sink stalling, both lightly.
  task automatic set_idling(input int profile);
    case (profile)
      0: begin sender_idle = 0;  sink_stall = 0;  end
      1: begin sender_idle = 77; sink_stall = 0;  end
      2: begin sender_idle = 0;  sink_stall = 77; end
      default: begin sender_idle = 6; sink_stall = 6; end
    endcase
  endtask

  // One item on the input channel. Entered and left just after a falling edge;
  // valid stays high on exit so back-to-back items follow without a gap.
  task automatic send_item(input logic mode, input int idx, input int x, input int y,
                           input int z, input int unsigned d);
    while ($urandom_range(99) < sender_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.mode           = mode;
    in_ch.particle_index = hsoc_pkg::IDX_W'(idx);
    in_ch.value_x        = x;
    in_ch.value_y        = y;
    in_ch.value_z        = z;
    in_ch.diameter       = hsoc_pkg::DIAM_W'(d);
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let a full scan pass:
  // a load gives no result, so the block may still be busy after the last one.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4 * ((cur_count > hsoc_pkg::MAX_PARTICLES) ? hsoc_pkg::MAX_PARTICLES : cur_count)
            + 16)
      @(negedge clk);
  endtask

  // APB transfer: setup cycle, then access until pready.
  task automatic reg_xfer(input hsoc_pkg::reg_t r, input logic wr,
                          input logic [hsoc_pkg::DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {r, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic read_back();
    reg_xfer(hsoc_pkg::REG_COUNT, 1'b0, '0);
    reg_xfer(hsoc_pkg::REG_BOX_X, 1'b0, '0);
    reg_xfer(hsoc_pkg::REG_BOX_Y, 1'b0, '0);
    reg_xfer(hsoc_pkg::REG_BOX_Z, 1'b0, '0);
  endtask

  // Registers are only touched with the block idle. Unused upper bits of each
  // write word are random; the block must ignore them.
  task automatic configure(input int count, input int bx, input int by, input int bz);
    logic [hsoc_pkg::DATA_W-1:0] word;
    settle();
    word = $urandom;
    word[hsoc_pkg::CNT_W-1:0] = hsoc_pkg::CNT_W'(count);
    reg_xfer(hsoc_pkg::REG_COUNT, 1'b1, word);
    word = $urandom;
    word[hsoc_pkg::BOX_W-1:0] = hsoc_pkg::BOX_W'(bx);
    reg_xfer(hsoc_pkg::REG_BOX_X, 1'b1, word);
    word = $urandom;
    word[hsoc_pkg::BOX_W-1:0] = hsoc_pkg::BOX_W'(by);
    reg_xfer(hsoc_pkg::REG_BOX_Y, 1'b1, word);
    word = $urandom;
    word[hsoc_pkg::BOX_W-1:0] = hsoc_pkg::BOX_W'(bz);
    reg_xfer(hsoc_pkg::REG_BOX_Z, 1'b1, word);
    read_back();
    cur_count = count;
    // a zero box does not fold; particles still need somewhere to sit
    span_x = (bx == 0) ? 4 * UNIT : bx;
    span_y = (by == 0) ? 4 * UNIT : by;
    span_z = (bz == 0) ? 4 * UNIT : bz;
  endtask

  // Coordinate spread evenly over one box length, centered on zero.
  function automatic int place(input int span);
    return int'($urandom_range(span - 1)) - span / 2;
  endfunction

  // Trial displacement of up to a quarter box either way.
  function automatic int nudge(input int span);
    return int'($urandom_range(span / 2)) - span / 4;
  endfunction

  // Mostly a few units; sometimes the extremes.
  function automatic int pick_box();
    case ($urandom_range(9))
      0: return 0;
      1: return 32'h7FFF_FFFF;
      default: return UNIT * int'($urandom_range(6, 1)) + int'($urandom_range(UNIT - 1));
    endcase
  endfunction

  // Load one particle inside the box, diameter between 1/12 and 1/3 of the
  // shortest side so that both overlap outcomes are common.
  task automatic place_particle(input int idx);
    int m;
    m = span_x;
    if (span_y < m) m = span_y;
    if (span_z < m) m = span_z;
    send_item(hsoc_pkg::MODE_LOAD, idx, place(span_x), place(span_y), place(span_z),
              $urandom_range(m / 3, m / 12));
  endtask

  // A small store: every particle below the count is loaded first, plus one
  // spare above it so that moves beyond the count never read an empty entry.
  task automatic random_phase(input int count);
    int          spare;
    int          idx;
    int unsigned r;
    configure(count, pick_box(), pick_box(), pick_box());
    for (int i = 0; i < count; i++) place_particle(i);
    spare = $urandom_range(hsoc_pkg::MAX_PARTICLES - 1, count);
    place_particle(spare);
    repeat ($urandom_range(40, 20)) begin
      r   = $urandom_range(99);
      idx = $urandom_range(count - 1);
      if (r < 70) begin
        send_item(hsoc_pkg::MODE_MOVE, idx, nudge(span_x), nudge(span_y), nudge(span_z),
                  $urandom);
      end else if (r < 80) begin
        send_item(hsoc_pkg::MODE_MOVE, spare, nudge(span_x), nudge(span_y), nudge(span_z),
                  $urandom);
      end else if (r < 88) begin
        place_particle(idx);
      end else if (r < 94) begin
        // noise: any bit pattern in position and diameter
        send_item(hsoc_pkg::MODE_LOAD, $urandom_range(1) ? idx : spare,
                  $urandom, $urandom, $urandom, $urandom);
      end else begin
        // full-range displacement, position wraps
        send_item(hsoc_pkg::MODE_MOVE, idx, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = hsoc_pkg::MODE_LOAD;
    in_ch.particle_index = '0;
    in_ch.value_x        = '0;
    in_ch.value_y        = '0;
    in_ch.value_z        = '0;
    in_ch.diameter       = '0;
    out_ch.ready         = 1'b0;
    span_x               = UNIT;
    span_y               = UNIT;
    span_z               = UNIT;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values of all registers
    read_back();

    // --- directed ---
    // Reset setting (count 1, unit box): particle 0 has no partner below the
    // count; particle 1 lies beyond the count and is still tested against 0.
    send_item(hsoc_pkg::MODE_LOAD, 0, 0, 0, 0, UNIT);
    send_item(hsoc_pkg::MODE_LOAD, 1, UNIT / 4, 0, 0, UNIT);
    send_item(hsoc_pkg::MODE_MOVE, 0, 0, 0, 0, 0);
    send_item(hsoc_pkg::MODE_MOVE, 1, 0, 0, 0, 0);

    // 4x4 box in x and y, zero box in z (difference left unfolded)
    configure(4, 4 * UNIT, 4 * UNIT, 0);
    send_item(hsoc_pkg::MODE_LOAD, 1, UNIT, 0, 0, UNIT);  // exactly touching 0: no overlap
    // meets 0 only across the edge
    send_item(hsoc_pkg::MODE_LOAD, 2, 7 * UNIT / 2, 0, 0, UNIT / 2);
    send_item(hsoc_pkg::MODE_LOAD, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    // diameter ignored on a move
    send_item(hsoc_pkg::MODE_MOVE, 1, 0, 0, 0, 32'h7FFF_FFFF);
    send_item(hsoc_pkg::MODE_MOVE, 0, 0, 0, 0, 0);
    send_item(hsoc_pkg::MODE_MOVE, 3, 1, -1, 1, 0);       // wraps on every axis
    send_item(hsoc_pkg::MODE_MOVE, 3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_item(hsoc_pkg::MODE_LOAD, 1023, -UNIT, -UNIT, -UNIT, 32'h7FFF_FFFF);
    send_item(hsoc_pkg::MODE_MOVE, 1023, 0, 0, 0, 0);     // top index, widest diameter

    // count zero: nothing is tested
    configure(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(hsoc_pkg::MODE_MOVE, 0, UNIT, UNIT, UNIT, 0);

    // maximum box on x, zero on y; one mover beyond the count, one within it
    configure(2, 32'h7FFF_FFFF, 0, UNIT);
    send_item(hsoc_pkg::MODE_MOVE, 3, 0, 0, 0, 0);
    send_item(hsoc_pkg::MODE_MOVE, 1, -UNIT, UNIT / 2, 0, 0);

    // --- random ---
    items_sent = 0;
    phase      = 0;
    while (items_sent < ITEM_BUDGET) begin
      set_idling(phase % 4);
      random_phase($urandom_range(12, 1));
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
